@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros clocked on clk with asynchronous reset arst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// shared sizes, codes and types of the software timer table
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int TIMER_SLOTS    = 8;
	localparam int CALLBACK_SLOTS = 64;
	localparam int MAX_RESULTS    = 8;

	localparam int OP_W    = 2;
	localparam int CB_W    = 6;
	localparam int DELAY_W = 31;
	localparam int CID_W   = 4;
	localparam int ID_W    = 4;
	localparam int TIME_W  = 32;

	localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int NF_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [8:0] CB_LIMIT = 9'(CALLBACK_SLOTS);

	localparam logic [OP_W-1:0] OP_SCHED = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	typedef enum logic [1:0] {
		K_SCHED = 2'd0,
		K_FULL  = 2'd1,
		K_CLEAR = 2'd2,
		K_FIRED = 2'd3
	} kind_t;

	typedef struct packed {
		logic               periodic;
		logic [CB_W-1:0]    cb;
		logic [DELAY_W-1:0] period;
		logic [TIME_W-1:0]  due;
	} slot_rec_t;

	localparam int REC_W = $bits(slot_rec_t);

	typedef struct packed {
		logic            valid;
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic [CB_W-1:0] cb;
		logic            last;
	} result_t;

	function automatic logic [ID_W-1:0] slot_to_id(input logic [SLOT_W-1:0] slot);
		logic [SLOT_W:0] s;
		s = {1'b0, slot} + 1'b1;
		return ID_W'(s);
	endfunction

endpackage

@@ rtl/stt_ram.sv @@
// ----------------------------------------------------------------------------
// stt_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module stt_ram #(
	parameter int DATA_W = 8,
	parameter int ADDR_W = 3
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/stt_ctrl.sv @@
// ----------------------------------------------------------------------------
// stt_ctrl
// op decode, slot allocation and tick scan over the slot record memory
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [stt_pkg::OP_W-1:0]       in_op,
	input  logic [stt_pkg::CB_W-1:0]       in_cb,
	input  logic [stt_pkg::DELAY_W-1:0]    in_delay,
	input  logic                           in_periodic,
	input  logic [stt_pkg::CID_W-1:0]      in_cid,
	input  logic                           out_free,
	output stt_pkg::result_t               push
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_EV,
		ST_FLUSH
	} state_t;

	localparam logic [stt_pkg::SLOT_W-1:0] LAST_SLOT =
		stt_pkg::SLOT_W'(stt_pkg::TIMER_SLOTS - 1);

	state_t                              state_q;
	logic [stt_pkg::TIMER_SLOTS-1:0]     used_q;
	logic [stt_pkg::TIME_W-1:0]          now_q;
	logic [stt_pkg::SLOT_W-1:0]          slot_q;
	logic [stt_pkg::NF_W-1:0]            nfired_q;
	logic                                pend_valid_q;
	stt_pkg::kind_t                      pend_kind_q;
	logic [stt_pkg::ID_W-1:0]            pend_id_q;
	logic [stt_pkg::CB_W-1:0]            pend_cb_q;

	logic                                accept;
	logic [stt_pkg::SLOT_W:0]            free_res;
	logic                                free_found;
	logic [stt_pkg::SLOT_W-1:0]          free_slot;
	logic                                cb_reject;
	logic                                cid_ok;
	logic [stt_pkg::SLOT_W-1:0]          cid_slot;
	logic [stt_pkg::REC_W-1:0]           rd_data;
	stt_pkg::slot_rec_t                  ev_rec;
	logic [stt_pkg::TIME_W-1:0]          diff;
	logic                                due_hit;
	logic                                ev_stall;
	logic                                wr_en;
	logic [stt_pkg::SLOT_W-1:0]          wr_addr;
	stt_pkg::slot_rec_t                  wr_rec;
	logic                                rd_en;

	function automatic logic [stt_pkg::SLOT_W:0] find_free(
		input logic [stt_pkg::TIMER_SLOTS-1:0] used
	);
		logic [stt_pkg::SLOT_W:0] res;
		res = '0;
		for (int i = stt_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				res = {1'b1, stt_pkg::SLOT_W'(i)};
			end
		end
		return res;
	endfunction

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign free_res   = find_free(used_q);
	assign free_found = free_res[stt_pkg::SLOT_W];
	assign free_slot  = free_res[stt_pkg::SLOT_W-1:0];
	assign cb_reject  = (9'(in_cb) >= stt_pkg::CB_LIMIT);
	assign cid_ok     = (in_cid != '0) && (32'(in_cid) <= stt_pkg::TIMER_SLOTS);
	assign cid_slot   = stt_pkg::SLOT_W'(in_cid - 1'b1);

	assign ev_rec   = stt_pkg::slot_rec_t'(rd_data);
	assign diff     = now_q - ev_rec.due;
	assign due_hit  = (state_q == ST_EV) && used_q[slot_q] && !diff[stt_pkg::TIME_W-1]
		&& (nfired_q < stt_pkg::NF_W'(stt_pkg::MAX_RESULTS));
	assign ev_stall = due_hit && pend_valid_q && !out_free;

	assign rd_en = (state_q == ST_RD) && used_q[slot_q];

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_rec  = ev_rec;
		if (accept && (in_op == stt_pkg::OP_SCHED) && !cb_reject && free_found) begin
			wr_en           = 1'b1;
			wr_addr         = free_slot;
			wr_rec.periodic = in_periodic;
			wr_rec.cb       = in_cb;
			wr_rec.period   = in_delay;
			wr_rec.due      = now_q + {1'b0, in_delay};
		end else if (due_hit && !ev_stall && ev_rec.periodic) begin
			wr_en      = 1'b1;
			wr_rec.due = now_q + {1'b0, ev_rec.period};
		end
	end

	always_comb begin
		push.valid = 1'b0;
		push.kind  = pend_kind_q;
		push.id    = pend_id_q;
		push.cb    = pend_cb_q;
		push.last  = 1'b1;
		if (state_q == ST_FLUSH) begin
			push.valid = pend_valid_q && out_free;
		end else if (due_hit) begin
			push.valid = pend_valid_q && out_free;
			push.last  = 1'b0;
		end
	end

	stt_ram #(
		.DATA_W (stt_pkg::REC_W),
		.ADDR_W (stt_pkg::SLOT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (slot_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			used_q       <= '0;
			now_q        <= '0;
			slot_q       <= '0;
			nfired_q     <= '0;
			pend_valid_q <= 1'b0;
			pend_kind_q  <= stt_pkg::K_SCHED;
			pend_id_q    <= '0;
			pend_cb_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_op)
							stt_pkg::OP_SCHED: begin
								pend_valid_q <= 1'b1;
								pend_cb_q    <= '0;
								if (cb_reject || !free_found) begin
									pend_kind_q <= stt_pkg::K_FULL;
									pend_id_q   <= '0;
								end else begin
									used_q[free_slot] <= 1'b1;
									pend_kind_q       <= stt_pkg::K_SCHED;
									pend_id_q         <= stt_pkg::slot_to_id(free_slot);
								end
								state_q <= ST_FLUSH;
							end
							stt_pkg::OP_CLEAR: begin
								if (cid_ok) begin
									used_q[cid_slot] <= 1'b0;
								end
								pend_valid_q <= 1'b1;
								pend_kind_q  <= stt_pkg::K_CLEAR;
								pend_id_q    <= '0;
								pend_cb_q    <= '0;
								state_q      <= ST_FLUSH;
							end
							stt_pkg::OP_TICK: begin
								now_q        <= now_q + 1'b1;
								slot_q       <= '0;
								nfired_q     <= '0;
								pend_valid_q <= 1'b0;
								state_q      <= ST_RD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RD: begin
					if (used_q[slot_q]) begin
						state_q <= ST_EV;
					end else if (slot_q == LAST_SLOT) begin
						state_q <= ST_FLUSH;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				ST_EV: begin
					if (!ev_stall) begin
						if (due_hit) begin
							if (!ev_rec.periodic) begin
								used_q[slot_q] <= 1'b0;
							end
							pend_valid_q <= 1'b1;
							pend_kind_q  <= stt_pkg::K_FIRED;
							pend_id_q    <= stt_pkg::slot_to_id(slot_q);
							pend_cb_q    <= ev_rec.cb;
							nfired_q     <= nfired_q + 1'b1;
						end
						if (slot_q == LAST_SLOT) begin
							state_q <= ST_FLUSH;
						end else begin
							slot_q  <= slot_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/software_timer_table_unit.sv @@
// ----------------------------------------------------------------------------
// software_timer_table_unit
// table of one-shot and periodic millisecond timers with a stream interface
// ----------------------------------------------------------------------------
// A beat with op schedule, clear or tick is taken only while no earlier beat
// is still being worked on; the previous result may still sit in the output
// register. Schedule and clear give a single result, which goes from the
// pending register into the output register once that register has room.
// A tick scans every slot in turn and stalls while the master side keeps
// the output register full: each used slot costs one registered read of the
// slot record memory and one pass through the evaluate state, and the last
// fired result is held back until the scan ends so that it can carry tlast.
// The slot records need no clearing pass after reset; only the used flags are
// cleared.
module software_timer_table_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // callback_index, delay_ms, periodic, clear_id
	input  logic [1:0]  s_tuser,   // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // timer_id, fired_callback
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast
);

	`include "assert_macros.svh"

	stt_pkg::result_t push;
	stt_pkg::result_t out_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_tready;

	stt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_op       (s_tuser),
		.in_cb       (s_tdata[5:0]),
		.in_delay    (s_tdata[36:6]),
		.in_periodic (s_tdata[37]),
		.in_cid      (s_tdata[41:38]),
		.out_free    (out_free),
		.push        (push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			out_q <= push;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.cb, out_q.id};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

	`ASSERT_IMPLY(a_push_needs_room, push.valid, out_free)
	`ASSERT_IMPLY(a_idle_no_push, s_tready, !push.valid)
	`ASSERT_IMPLY(a_single_reply_last, push.valid && (push.kind != stt_pkg::K_FIRED), push.last)
	`ASSERT_NEXT(a_push_shows, push.valid, m_tvalid)

endmodule

@@ tb/timer_table_checker.sv @@
// ----------------------------------------------------------------------------
// timer_table_checker
// Watches both stream channels of the software timer table. Every request beat
// taken in is run through a local copy of the timer table. The answers that the
// copy gives are queued in order. Every result beat given out is compared field
// by field with the oldest queued answer. Mismatches and unexpected beats are
// counted. The count and the number of answers still owed go to the top.
// ----------------------------------------------------------------------------
module timer_table_checker
	import stt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,   // callback_index, delay_ms, periodic, clear_id
	input  logic [1:0]  s_tuser,   // op
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // timer_id, fired_callback
	input  logic [1:0]  m_tuser,   // kind
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		kind_t           kind;
		logic [ID_W-1:0] id;
		logic [CB_W-1:0] cb;
		logic            is_last;
	} answer_t;

	answer_t answers_due[$];

	logic               slot_busy     [TIMER_SLOTS];
	logic               slot_repeat   [TIMER_SLOTS];
	logic [CB_W-1:0]    slot_cb       [TIMER_SLOTS];
	logic [DELAY_W-1:0] slot_interval [TIMER_SLOTS];
	logic [TIME_W-1:0]  slot_deadline [TIMER_SLOTS];
	logic [TIME_W-1:0]  clock_ms;

	function automatic void run_request(input logic [OP_W-1:0] op, input logic [CB_W-1:0] cb,
			input logic [DELAY_W-1:0] delay, input logic rep, input logic [CID_W-1:0] cid);
		int slot;
		int n;
		logic [TIME_W-1:0] lag;
		answer_t fired[$];
		slot = 0;
		n = 0;
		case (op)
		OP_SCHED: begin
			while (slot < TIMER_SLOTS && slot_busy[slot])
				slot++;
			if (int'(cb) >= CALLBACK_SLOTS || slot == TIMER_SLOTS) begin
				answers_due.push_back('{K_FULL, '0, '0, 1'b1});
			end else begin
				slot_busy[slot]     = 1'b1;
				slot_repeat[slot]   = rep;
				slot_cb[slot]       = cb;
				slot_interval[slot] = delay;
				slot_deadline[slot] = clock_ms + TIME_W'(delay);
				answers_due.push_back('{K_SCHED, ID_W'(slot + 1), '0, 1'b1});
			end
		end
		OP_CLEAR: begin
			if (cid >= 1 && cid <= TIMER_SLOTS)
				slot_busy[cid - 1] = 1'b0;
			answers_due.push_back('{K_CLEAR, '0, '0, 1'b1});
		end
		OP_TICK: begin
			clock_ms = clock_ms + 1'b1;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				lag = clock_ms - slot_deadline[i];
				if (slot_busy[i] && !lag[TIME_W-1] && n < MAX_RESULTS) begin
					if (slot_repeat[i])
						slot_deadline[i] = clock_ms + TIME_W'(slot_interval[i]);
					else
						slot_busy[i] = 1'b0;
					fired.push_back('{K_FIRED, ID_W'(i + 1), slot_cb[i], 1'b0});
					n++;
				end
			end
			// only the final beat of a tick carries tlast
			if (n > 0)
				fired[n - 1].is_last = 1'b1;
			answers_due = {answers_due, fired};
		end
		default: ;
		endcase
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		answer_t got;
		if (!arst_n) begin
			foreach (slot_busy[i])
				slot_busy[i] = 1'b0;
			clock_ms = '0;
			answers_due.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// results leave through the pending and output registers after their request, so pop first
			if (m_tvalid && m_tready) begin
				got = '{kind_t'(m_tuser), m_tdata[3:0], m_tdata[9:4], m_tlast};
				if (answers_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, got kind %0d id %0d cb %0d last %0b",
						$time, got.kind, got.id, got.cb, got.is_last);
				end else begin
					want = answers_due.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("timer_id", want.id, got.id);
					check_field("fired_callback", want.cb, got.cb);
					check_field("last", want.is_last, got.is_last);
				end
			end
			if (s_tvalid && s_tready)
				run_request(s_tuser, s_tdata[5:0], s_tdata[36:6], s_tdata[37], s_tdata[41:38]);
			pending <= answers_due.size();
		end
	end

endmodule

@@ tb/tb_software_timer_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_software_timer_table_unit
// Drives schedule, clear and tick requests into the timer table. A short
// directed opening fills the table and fires many timers at once. Random
// traffic follows: mostly bursts that free the table, rearm all slots and tick
// them off, mixed with single random requests. Both channels idle at random.
// The result side holds off once for a long stretch. Checking is done in
// timer_table_checker.
// ----------------------------------------------------------------------------
module tb_software_timer_table_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import stt_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int REQUESTS = 410;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // callback_index, delay_ms, periodic, clear_id
	logic [1:0]  s_tuser = '0;   // op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // timer_id, fired_callback
	logic [1:0]  m_tuser;        // kind
	logic        m_tlast;
	int          errors;
	int          pending;
	int          sent = 0;
	bit          steady = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	software_timer_table_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	timer_table_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	task automatic send_request(input logic [OP_W-1:0] op, input logic [CB_W-1:0] cb,
			input logic [DELAY_W-1:0] delay, input logic rep, input logic [CID_W-1:0] cid);
		int gap;
		if (sent % 40 == 0)
			steady = ($urandom_range(0, 2) == 0);
		gap = steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, cid, rep, delay, cb};
		do @(posedge clk); while (!s_tready);
		if (op != OP_UNUSED)
			sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int roll;
		bit paused;
		logic [OP_W-1:0] op;
		logic [CB_W-1:0] cb;
		logic [DELAY_W-1:0] delay;
		logic rep;
		logic [CID_W-1:0] cid;
		paused = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tick, unused op, clears of unknown and free ids
		send_request(OP_TICK, '0, '0, 1'b0, '0);
		send_request(OP_UNUSED, '1, '1, 1'b1, '1);
		send_request(OP_CLEAR, '0, '0, 1'b0, 4'd0);
		send_request(OP_CLEAR, '1, '1, 1'b1, 4'd15);
		send_request(OP_CLEAR, '0, '0, 1'b0, 4'd3);
		// fill the table, then one more schedule finds it full
		send_request(OP_SCHED, 6'd0, '0, 1'b0, '0);
		send_request(OP_SCHED, 6'd63, '1, 1'b1, '0);
		for (int k = 2; k < TIMER_SLOTS; k++)
			send_request(OP_SCHED, CB_W'(k * 7), DELAY_W'(1), k[0], '0);
		send_request(OP_SCHED, 6'd9, DELAY_W'(5), 1'b0, '0);
		send_request(OP_TICK, '0, '0, 1'b0, '0);
		send_request(OP_TICK, '0, '0, 1'b0, '0);
		send_request(OP_CLEAR, '0, '0, 1'b0, 4'd2);
		send_request(OP_SCHED, 6'd33, '0, 1'b0, '0);
		send_request(OP_TICK, '0, '0, 1'b0, '0);
		send_request(OP_TICK, '0, '0, 1'b0, '0);
		send_request(OP_CLEAR, '0, '0, 1'b0, 4'd8);
		wait_drained();

		while (sent < REQUESTS) begin
			if (sent >= REQUESTS / 2 && !paused) begin
				wait_drained();
				paused = 1'b1;
			end
			cb    = CB_W'($urandom);
			delay = ($urandom_range(0, 6) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 15));
			rep   = 1'($urandom);
			cid   = ($urandom_range(0, 3) == 0) ? CID_W'($urandom) : CID_W'($urandom_range(1, TIMER_SLOTS));
			if ($urandom_range(0, 4) == 0) begin
				// free every slot, arm all of them close together, then tick them off
				for (int k = 1; k <= TIMER_SLOTS; k++)
					send_request(OP_CLEAR, cb, delay, rep, CID_W'(k));
				for (int k = 0; k < TIMER_SLOTS; k++)
					send_request(OP_SCHED, CB_W'($urandom), DELAY_W'($urandom_range(0, 3)),
						1'($urandom), cid);
				repeat ($urandom_range(3, 6))
					send_request(OP_TICK, cb, delay, rep, cid);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 5)
					op = OP_UNUSED;
				else if (roll < 35)
					op = OP_SCHED;
				else if (roll < 50)
					op = OP_CLEAR;
				else
					op = OP_TICK;
				send_request(op, cb, delay, rep, cid);
			end
		end
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_software_timer_table_unit: done, clean");
		else
			$display("tb_software_timer_table_unit: done, errors");
		$finish;
	end

	initial begin : result_sink
		int got;
		int gap;
		bit calm;
		got = 0;
		calm = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (got % 32 == 0)
				calm = ($urandom_range(0, 2) == 0);
			// one long hold while requests keep coming
			if (got == 60)
				gap = HOLD_CYCLES;
			else
				gap = calm ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got++;
		end
	end

	initial begin : watchdog
		#1_000_000;
		$display("tb_software_timer_table_unit: done, errors");
		$finish;
	end

endmodule

@@ software_timer_table_unit.f @@
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_ram.sv
rtl/stt_ctrl.sv
rtl/software_timer_table_unit.sv
tb/timer_table_checker.sv
tb/tb_software_timer_table_unit.sv
